// ===== design/assert_macros.svh =====
// assertion macros used by the rtl file grow_light_daylight_supplement_fsm_core
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// implication checked at every clock edge outside reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/glds_pkg.sv =====
// constants and types for the grow light daylight supplement controller
// no dependencies
package glds_pkg;

  localparam int unsigned TimeW   = 17;
  localparam int unsigned LuxW    = 7;
  localparam int unsigned CountW  = 32;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned AddrW   = 4;
  localparam int unsigned DataW   = 32;

  // mode codes
  localparam logic [ModeW-1:0] ModeIdle  = 2'd0;
  localparam logic [ModeW-1:0] ModeSense = 2'd1;
  localparam logic [ModeW-1:0] ModeLit   = 2'd2;

  // register indexes
  localparam logic [1:0] RegSunrise   = 2'd0;
  localparam logic [1:0] RegSunset    = 2'd1;
  localparam logic [1:0] RegRequired  = 2'd2;
  localparam logic [1:0] RegThreshold = 2'd3;

  localparam logic [TimeW-1:0]  SunriseReset   = 17'd28800;
  localparam logic [TimeW-1:0]  SunsetReset    = 17'd64800;
  localparam logic [CountW-1:0] RequiredReset  = 32'd18000;
  localparam logic [LuxW-1:0]   ThresholdReset = 7'd80;

  localparam logic ActTick  = 1'b0;
  localparam logic ActQuery = 1'b1;

  typedef struct packed {
    logic [TimeW-1:0]  sunrise;
    logic [TimeW-1:0]  sunset;
    logic [CountW-1:0] required;
    logic [LuxW-1:0]   threshold;
  } cfg_t;

endpackage

// ===== design/grow_light_daylight_supplement_fsm_core.sv =====
// top level of the grow light daylight supplement controller
// depends on glds_pkg and assert_macros.svh
//
//  channel   direction  handshake                 payload
//  in        input      in_valid_i / in_ready_o   action_i, time_of_day_i, light_intensity_i
//  out       output     out_valid_o / out_ready_i lamp_on_o, mode_o, mode_announced_o,
//                                                 lit_amount_o, amount_announced_o
//  cfg       input      psel/penable/pwrite       paddr, pwdata, prdata, pready
//
// one transaction per cycle while the output is not stalled; a result passes from the input register
// through the mode step into the result register
// the mode step reads and writes the state registers in the same cycle, so back to back
// ticks see each other's state
// reset puts the mode at idle, clears both counts and loads default register values
// a stalled output holds both stages; the input register still fills if empty
`include "assert_macros.svh"

module grow_light_daylight_supplement_fsm_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                action_i,
  input  logic [glds_pkg::TimeW-1:0]          time_of_day_i,
  input  logic [glds_pkg::LuxW-1:0]           light_intensity_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                lamp_on_o,
  output logic [glds_pkg::ModeW-1:0]          mode_o,
  output logic                                mode_announced_o,
  output logic [glds_pkg::CountW-1:0]         lit_amount_o,
  output logic                                amount_announced_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [glds_pkg::AddrW-1:0]          paddr,
  input  logic [glds_pkg::DataW-1:0]          pwdata,
  output logic [glds_pkg::DataW-1:0]          prdata,
  output logic                                pready
);

  glds_pkg::cfg_t cfg_q;

  logic                          s1_valid_q;
  logic                          s1_action_q;
  logic [glds_pkg::TimeW-1:0]    s1_time_q;
  logic [glds_pkg::LuxW-1:0]     s1_lux_q;

  logic [glds_pkg::ModeW-1:0]    mode_q, mode_d;
  logic [glds_pkg::CountW-1:0]   count_q, count_d;
  logic [glds_pkg::CountW-1:0]   last_rep_q, last_rep_d;

  logic                          out_valid_q;
  logic                          lamp_q;
  logic [glds_pkg::ModeW-1:0]    out_mode_q;
  logic                          mode_ann_q, mode_ann_d;
  logic [glds_pkg::CountW-1:0]   amount_q;
  logic                          amt_ann_q, amt_ann_d;

  logic out_free;
  logic s1_advance;
  logic in_fire;
  logic cfg_write;
  logic [1:0] reg_idx;

  logic day, night, done, bright;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_advance = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_idx   = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sunrise   <= glds_pkg::SunriseReset;
      cfg_q.sunset    <= glds_pkg::SunsetReset;
      cfg_q.required  <= glds_pkg::RequiredReset;
      cfg_q.threshold <= glds_pkg::ThresholdReset;
    end else if (cfg_write) begin
      unique case (reg_idx)
        glds_pkg::RegSunrise:   cfg_q.sunrise   <= pwdata[glds_pkg::TimeW-1:0];
        glds_pkg::RegSunset:    cfg_q.sunset    <= pwdata[glds_pkg::TimeW-1:0];
        glds_pkg::RegRequired:  cfg_q.required  <= pwdata[glds_pkg::CountW-1:0];
        glds_pkg::RegThreshold: cfg_q.threshold <= pwdata[glds_pkg::LuxW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      glds_pkg::RegSunrise:
        prdata = {{(glds_pkg::DataW-glds_pkg::TimeW){1'b0}}, cfg_q.sunrise};
      glds_pkg::RegSunset:
        prdata = {{(glds_pkg::DataW-glds_pkg::TimeW){1'b0}}, cfg_q.sunset};
      glds_pkg::RegRequired:
        prdata = cfg_q.required;
      glds_pkg::RegThreshold:
        prdata = {{(glds_pkg::DataW-glds_pkg::LuxW){1'b0}}, cfg_q.threshold};
      default:
        prdata = '0;
    endcase
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_action_q <= action_i;
      s1_time_q   <= time_of_day_i;
      s1_lux_q    <= light_intensity_i;
    end
  end

  // mode step
  assign day    = (cfg_q.sunrise < s1_time_q) && (s1_time_q < cfg_q.sunset);
  assign night  = (cfg_q.sunset < s1_time_q) || (s1_time_q < cfg_q.sunrise);
  assign done   = count_q >= cfg_q.required;
  assign bright = s1_lux_q >= cfg_q.threshold;

  always_comb begin
    mode_d     = mode_q;
    count_d    = count_q;
    last_rep_d = last_rep_q;
    mode_ann_d = 1'b1;
    amt_ann_d  = 1'b1;
    if (s1_action_q == glds_pkg::ActTick) begin
      unique case (mode_q)
        glds_pkg::ModeSense: begin
          if (done) begin
            mode_d = glds_pkg::ModeIdle;
          end else if (night) begin
            mode_d = glds_pkg::ModeLit;
          end else if (bright) begin
            count_d = count_q + 32'd1;
          end
        end
        glds_pkg::ModeLit: begin
          if (day) begin
            count_d = '0;
            mode_d  = glds_pkg::ModeSense;
          end else if (done) begin
            mode_d = glds_pkg::ModeIdle;
          end else if (bright) begin
            count_d = count_q + 32'd1;
          end
        end
        default: begin
          // idle, and the unused code behaves as idle
          if (day) begin
            count_d = '0;
            mode_d  = glds_pkg::ModeSense;
          end else if (!done) begin
            mode_d = glds_pkg::ModeLit;
          end else begin
            mode_d = glds_pkg::ModeIdle;
          end
        end
      endcase
      mode_ann_d = (mode_d != mode_q);
      amt_ann_d  = (count_d != last_rep_q);
      last_rep_d = count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= glds_pkg::ModeIdle;
      count_q     <= '0;
      last_rep_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
      if (s1_advance) begin
        mode_q     <= mode_d;
        count_q    <= count_d;
        last_rep_q <= last_rep_d;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      lamp_q     <= (mode_d == glds_pkg::ModeLit);
      out_mode_q <= mode_d;
      mode_ann_q <= mode_ann_d;
      amount_q   <= last_rep_d;
      amt_ann_q  <= amt_ann_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign lamp_on_o          = lamp_q;
  assign mode_o             = out_mode_q;
  assign mode_announced_o   = mode_ann_q;
  assign lit_amount_o       = amount_q;
  assign amount_announced_o = amt_ann_q;

  `ASSERT_IMPL(a_lamp_follows_mode, clk_i, rst_ni, out_valid_q,
               lamp_q == (out_mode_q == glds_pkg::ModeLit))
  `ASSERT_IMPL(a_result_matches_state, clk_i, rst_ni, out_valid_q,
               (amount_q == last_rep_q) && (out_mode_q == mode_q))
  `ASSERT_NEXT(a_tick_reports_count, clk_i, rst_ni,
               s1_advance && (s1_action_q == glds_pkg::ActTick), last_rep_q == count_q)
  `ASSERT_NEXT(a_stage_holds_on_stall, clk_i, rst_ni, s1_valid_q && !out_free,
               s1_valid_q && $stable(s1_time_q) && $stable(s1_action_q))

endmodule
